[sv/keyboard_pointer_accelerator_unit_defines.svh]
// Assertion helpers for the top-level RTL file.
`ifndef KEYBOARD_POINTER_ACCELERATOR_UNIT_DEFINES_SVH
`define KEYBOARD_POINTER_ACCELERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define KPA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define KPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/kpa_pkg.sv]
package kpa_pkg;

    // item kinds
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_KEY   = 2'd1;
    localparam logic [1:0] FUNC_RESET = 2'd2;

    // decoded direction keys
    localparam logic [2:0] DIR_UP    = 3'd1;
    localparam logic [2:0] DIR_DOWN  = 3'd2;
    localparam logic [2:0] DIR_LEFT  = 3'd3;
    localparam logic [2:0] DIR_RIGHT = 3'd4;

    localparam logic [3:0] DIGIT_MAX = 4'd9;

    // register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_START_SPEED   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TOP_SPEED     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_RATE    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_JUMP_UNIT     = 3'd5;
    localparam int CFG_DATA_W = 32;

    // register defaults
    localparam logic [23:0] START_SPEED_RST   = 24'd14418;
    localparam logic [23:0] TOP_SPEED_RST     = 24'd104858;
    localparam logic [31:0] ACCEL_RATE_RST    = 32'd3006477;
    localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd1920;
    localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd1080;
    localparam logic [9:0]  JUMP_UNIT_RST     = 10'd10;

    localparam int KPA_COUNT_MAX = 9999;

    // jump arithmetic: 24-bit distance plus 16-bit pointer, signed
    localparam int JUMP_W = 26;
    localparam logic signed [JUMP_W-1:0] S24_MAX = 26'sd8388607;
    localparam logic signed [JUMP_W-1:0] S24_MIN = -26'sd8388608;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  key_direction;
        logic [3:0]  key_digit;
        logic        has_modifiers;
        logic        pressed;
        logic [15:0] elapsed;
        logic [15:0] pointer_x;
        logic [15:0] pointer_y;
    } in_item_t;

    typedef struct packed {
        logic               handled;
        logic               move_valid;
        logic signed [23:0] move_x;
        logic signed [23:0] move_y;
    } out_item_t;

    typedef struct packed {
        logic [23:0] start_speed;
        logic [23:0] top_speed;
        logic [31:0] accel_rate;
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [9:0]  jump_unit;
    } cfg_t;

endpackage

[sv/kpa_cfg_regs.sv]
module kpa_cfg_regs
    import kpa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_speed   <= START_SPEED_RST;
            cfg_reg.top_speed     <= TOP_SPEED_RST;
            cfg_reg.accel_rate    <= ACCEL_RATE_RST;
            cfg_reg.screen_width  <= SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RST;
            cfg_reg.jump_unit     <= JUMP_UNIT_RST;
        end else if (wr_en) begin
            case (wr_index)
                REG_START_SPEED:   cfg_reg.start_speed   <= wr_data[23:0];
                REG_TOP_SPEED:     cfg_reg.top_speed     <= wr_data[23:0];
                REG_ACCEL_RATE:    cfg_reg.accel_rate    <= wr_data;
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= wr_data[15:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= wr_data[15:0];
                REG_JUMP_UNIT:     cfg_reg.jump_unit     <= wr_data[9:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/kpa_step.sv]
module kpa_step
    import kpa_pkg::*;
#(
    parameter int COUNT_MAX = KPA_COUNT_MAX
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result_next
);

    localparam int CW = $clog2(COUNT_MAX + 1);
    localparam logic [CW+3:0] TEN     = (CW + 4)'(10);
    localparam logic [CW+3:0] CNT_TOP = (CW + 4)'(COUNT_MAX);

    // persistent state
    logic          held_left_reg, held_right_reg, held_up_reg, held_down_reg;
    logic [CW-1:0] count_reg;
    logic          at_rest_reg;
    logic [31:0]   cursor_x_reg, cursor_y_reg;
    logic [23:0]   velocity_reg;

    logic          held_left_next, held_right_next, held_up_next, held_down_next;
    logic [CW-1:0] count_next;
    logic          at_rest_next;
    logic [31:0]   cursor_x_next, cursor_y_next;
    logic [23:0]   velocity_next;

    // decode
    logic is_key, is_digit, dir_hit, jump, tick, moving;
    logic l_mid, r_mid, u_mid, d_mid;

    // digit path
    logic [CW+3:0] cnt_acc;
    logic [CW-1:0] cnt_digit;

    // jump path
    logic [CW+9:0]             jump_dist;
    logic signed [JUMP_W-1:0]  dist_s, jx_pos, jy_pos, jx_sat, jy_sat;

    // tick path
    logic [23:0]        vel_use;
    logic [39:0]        step_prod;
    logic [47:0]        gain_prod;
    logic [24:0]        vel_sum;
    logic [31:0]        base_x, base_y;
    logic signed [33:0] step_s, pos_x, pos_y;
    logic [31:0]        hi_x, hi_y, cx_new, cy_new;

    always_comb begin
        is_key   = (item.func == FUNC_KEY);
        is_digit = is_key && (item.key_digit <= DIGIT_MAX) && !item.has_modifiers;
        dir_hit  = is_key && !is_digit &&
                   (item.key_direction >= DIR_UP) && (item.key_direction <= DIR_RIGHT);

        // flags after the key update or the reset item
        l_mid = held_left_reg;
        r_mid = held_right_reg;
        u_mid = held_up_reg;
        d_mid = held_down_reg;
        if (item.func == FUNC_RESET) begin
            {l_mid, r_mid, u_mid, d_mid} = 4'b0000;
        end else if (is_key && !is_digit) begin
            case (item.key_direction)
                DIR_UP:    u_mid = item.pressed;
                DIR_DOWN:  d_mid = item.pressed;
                DIR_LEFT:  l_mid = item.pressed;
                DIR_RIGHT: r_mid = item.pressed;
                default: ;
            endcase
        end

        jump = dir_hit && (count_reg != '0);
        tick = (item.func == FUNC_TICK) || (item.func == FUNC_RESET) ||
               (is_key && !is_digit && !jump);
        moving = tick && ((l_mid != r_mid) || (u_mid != d_mid));

        // decimal count, saturating
        cnt_acc   = (CW + 4)'(count_reg) * TEN + (CW + 4)'(item.key_digit);
        cnt_digit = (cnt_acc > CNT_TOP) ? CW'(COUNT_MAX) : cnt_acc[CW-1:0];

        // jump target, saturated to signed 24 bits
        jump_dist = cfg.jump_unit * (CW + 10)'(count_reg);
        dist_s    = signed'(JUMP_W'(jump_dist));
        jx_pos    = signed'(JUMP_W'(item.pointer_x));
        jy_pos    = signed'(JUMP_W'(item.pointer_y));
        if (r_mid && !l_mid) jx_pos = jx_pos + dist_s;
        if (l_mid && !r_mid) jx_pos = jx_pos - dist_s;
        if (d_mid && !u_mid) jy_pos = jy_pos + dist_s;
        if (u_mid && !d_mid) jy_pos = jy_pos - dist_s;
        jx_sat = (jx_pos > S24_MAX) ? S24_MAX : ((jx_pos < S24_MIN) ? S24_MIN : jx_pos);
        jy_sat = (jy_pos > S24_MAX) ? S24_MAX : ((jy_pos < S24_MIN) ? S24_MIN : jy_pos);

        // motion: leaving rest reloads cursor and velocity first
        vel_use   = at_rest_reg ? cfg.start_speed : velocity_reg;
        base_x    = at_rest_reg ? {item.pointer_x, 16'h0000} : cursor_x_reg;
        base_y    = at_rest_reg ? {item.pointer_y, 16'h0000} : cursor_y_reg;
        step_prod = 40'(vel_use) * 40'(item.elapsed);
        step_s    = signed'(34'(step_prod[39:10]));
        pos_x     = signed'(34'(base_x));
        pos_y     = signed'(34'(base_y));
        if (r_mid && !l_mid) pos_x = pos_x + step_s;
        if (l_mid && !r_mid) pos_x = pos_x - step_s;
        if (d_mid && !u_mid) pos_y = pos_y + step_s;
        if (u_mid && !d_mid) pos_y = pos_y - step_s;
        hi_x   = {cfg.screen_width, 16'h0000};
        hi_y   = {cfg.screen_height, 16'h0000};
        cx_new = (pos_x < 0) ? 32'h0 :
                 ((pos_x > signed'(34'(hi_x))) ? hi_x : pos_x[31:0]);
        cy_new = (pos_y < 0) ? 32'h0 :
                 ((pos_y > signed'(34'(hi_y))) ? hi_y : pos_y[31:0]);

        gain_prod = 48'(item.elapsed) * 48'(cfg.accel_rate);
        vel_sum   = 25'(vel_use) + 25'(gain_prod[47:26]);

        // next state
        held_left_next  = jump ? 1'b0 : l_mid;
        held_right_next = jump ? 1'b0 : r_mid;
        held_up_next    = jump ? 1'b0 : u_mid;
        held_down_next  = jump ? 1'b0 : d_mid;

        count_next = count_reg;
        if ((item.func == FUNC_RESET) || jump) begin
            count_next = '0;
        end else if (is_digit && item.pressed) begin
            count_next = cnt_digit;
        end

        at_rest_next  = tick ? !moving : at_rest_reg;
        cursor_x_next = moving ? cx_new : cursor_x_reg;
        cursor_y_next = moving ? cy_new : cursor_y_reg;
        velocity_next = velocity_reg;
        if (moving) begin
            velocity_next = (vel_sum > 25'(cfg.top_speed)) ? cfg.top_speed : vel_sum[23:0];
        end

        // result
        result_next.handled    = is_digit ? (count_next != '0) : dir_hit;
        result_next.move_valid = jump || moving;
        if (jump) begin
            result_next.move_x = jx_sat[23:0];
            result_next.move_y = jy_sat[23:0];
        end else if (moving) begin
            result_next.move_x = signed'(24'(cx_new[31:16]));
            result_next.move_y = signed'(24'(cy_new[31:16]));
        end else begin
            result_next.move_x = '0;
            result_next.move_y = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_left_reg  <= 1'b0;
            held_right_reg <= 1'b0;
            held_up_reg    <= 1'b0;
            held_down_reg  <= 1'b0;
            count_reg      <= '0;
            at_rest_reg    <= 1'b1;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            velocity_reg   <= '0;
        end else if (en) begin
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
            held_up_reg    <= held_up_next;
            held_down_reg  <= held_down_next;
            count_reg      <= count_next;
            at_rest_reg    <= at_rest_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            velocity_reg   <= velocity_next;
        end
    end

endmodule

[sv/keyboard_pointer_accelerator_unit.sv]
// Channel  | Ports                                       | Direction
// ---------+---------------------------------------------+----------
// input    | s_valid, s_ready, s_item (in_item_t)        | in
// result   | m_valid, m_ready, m_item (out_item_t)       | out
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data   | in
//
// One item per cycle sustained while m_ready stays high; every item gives exactly one result item.
// Each item passes the input register, then the result register, with
// the whole step (multipliers, adds, clamps) evaluated in between.
// The state update sits in that same step, so the next item sees it at once.
// Reset is synchronous, active low: state and config go to their defaults.
// With m_ready low the result holds; one more item parks in the input
// register, then s_ready drops. Config writes are always taken (cfg_ready=1).
`include "keyboard_pointer_accelerator_unit_defines.svh"

module keyboard_pointer_accelerator_unit
    import kpa_pkg::*;
#(
    parameter int COUNT_MAX = KPA_COUNT_MAX
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_vld_reg;
    out_item_t out_item_reg;
    logic      out_vld_reg;
    out_item_t result_next;
    logic      out_free;
    logic      advance;

    assign cfg_ready = 1'b1;

    kpa_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // the result slot frees up when empty or being taken
    assign out_free = !out_vld_reg || m_ready;
    // the staged item runs through the step and commits state
    assign advance  = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || advance;

    kpa_step #(
        .COUNT_MAX (COUNT_MAX)
    ) u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .item        (in_item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= result_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_item  = out_item_reg;

    `KPA_ASSERT_NOW(a_full_blocks_input, aclk, aresetn,
        in_vld_reg && out_vld_reg && !m_ready, !s_ready,
        "input taken while both stages are full")

    `KPA_ASSERT_NEXT(a_accept_fills_stage, aclk, aresetn,
        s_valid && s_ready, in_vld_reg,
        "accepted item not staged")

    `KPA_ASSERT_NEXT(a_advance_fills_result, aclk, aresetn,
        advance, m_valid,
        "stepped item produced no result")

    `KPA_ASSERT_NOW(a_no_move_zero_pos, aclk, aresetn,
        m_valid && !m_item.move_valid, (m_item.move_x == '0) && (m_item.move_y == '0),
        "nonzero position on a result without move")

endmodule
